// ===== design/crle_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// crle_pkg
// shared types, widths and helpers of the closed-loop catmull-rom evaluator
// ----------------------------------------------------------------------------
package crle_pkg;

	localparam int COORD_W = 16;
	localparam int PARAM_W = 16;
	localparam int COUNT_W = 4;
	localparam int RES_W   = 20;
	localparam int POINT_W = 3 * COORD_W;

	localparam logic [COUNT_W-1:0] MIN_POINTS = 4'd4;
	localparam logic [COUNT_W-1:0] RESET_POINTS = 4'd5;

	localparam logic MODE_WRITE = 1'b0;
	localparam logic MODE_EVAL  = 1'b1;

	localparam logic signed [24:0] SAT_HI = 25'sd524287;
	localparam logic signed [24:0] SAT_LO = -25'sd524288;

	// stage load enables handed to the arithmetic lanes
	typedef struct packed {
		logic ld_s3;
		logic ld_s4;
		logic ld_s5;
		logic ld_s6;
		logic ld_s7;
		logic ld_s8;
		logic ld_s9;
	} crle_adv_t;

	function automatic logic signed [RES_W-1:0] sat20(input logic signed [24:0] v);
		if (v > SAT_HI)
			return SAT_HI[RES_W-1:0];
		else if (v < SAT_LO)
			return SAT_LO[RES_W-1:0];
		else
			return v[RES_W-1:0];
	endfunction

endpackage
`default_nettype wire

// ===== design/crle_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// crle_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module crle_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 8
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
	end

	always_ff @(posedge clk) begin
		if (re)
			rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// ===== design/crle_lane.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// crle_lane
// one coordinate of the spline evaluation, stages s3 to s9
// ----------------------------------------------------------------------------
module crle_lane (
	input  wire logic                                  clk,
	input  wire crle_pkg::crle_adv_t                   adv,
	input  wire logic        [crle_pkg::PARAM_W-1:0]   f_s2,
	input  wire logic signed [crle_pkg::COORD_W-1:0]   p0,
	input  wire logic signed [crle_pkg::COORD_W-1:0]   p1,
	input  wire logic signed [crle_pkg::COORD_W-1:0]   p2,
	input  wire logic signed [crle_pkg::COORD_W-1:0]   p3,
	output logic signed      [crle_pkg::RES_W-1:0]     pos,
	output logic signed      [crle_pkg::RES_W-1:0]     der
);

	// coefficients
	logic signed [20:0] e0, e1, e2, e3;
	logic signed [20:0] a3_w, a3x3_w, a2_w, a1_w;
	logic signed [18:0] a3_s3;
	logic signed [20:0] a3x3_s3;
	logic signed [19:0] a2_s3, a2_s4;
	logic signed [16:0] a1_s3, a1_s4, a1_s5, a1_s6;
	logic signed [15:0] p1_s3, p1_s4, p1_s5, p1_s6, p1_s7, p1_s8;
	logic        [15:0] f_s3, f_s4, f_s5, f_s6, f_s7;

	logic signed [16:0] fx_s3, fx_s5, fx_s7;
	logic signed [35:0] m1_s4;
	logic signed [37:0] md1_s4;
	logic signed [36:0] u_s5;
	logic signed [38:0] v_s5;
	logic signed [53:0] uf_s6;
	logic signed [55:0] vf_s6;
	logic signed [55:0] hsum;
	logic signed [56:0] gsum;
	logic signed [39:0] h_s7;
	logic signed [19:0] der_s7, der_s8;
	logic signed [56:0] hf_s8;
	logic signed [56:0] psum;
	logic signed [24:0] pos_full;

	assign e0 = 21'(p0);
	assign e1 = 21'(p1);
	assign e2 = 21'(p2);
	assign e3 = 21'(p3);

	assign a3_w   = e3 - e0 + (e1 <<< 1) + e1 - (e2 <<< 1) - e2;
	assign a3x3_w = (a3_w <<< 1) + a3_w;
	assign a2_w   = (e0 <<< 1) - (e1 <<< 2) - e1 + (e2 <<< 2) - e3;
	assign a1_w   = e2 - e0;

	assign fx_s3 = signed'({1'b0, f_s3});
	assign fx_s5 = signed'({1'b0, f_s5});
	assign fx_s7 = signed'({1'b0, f_s7});

	// h and derivative sums, rounded half up by adding half an lsb
	assign hsum = 56'(uf_s6) + (56'(a1_s6) <<< 32) + 56'sd32768;
	assign gsum = 57'(vf_s6) + (57'(a1_s6) <<< 32) + (57'sd1 <<< 32);
	assign psum = hf_s8 + (57'sd1 <<< 32);
	assign pos_full = 25'(p1_s8) + 25'(signed'(psum[56:33]));

	always_ff @(posedge clk) begin
		if (adv.ld_s3) begin
			a3_s3   <= a3_w[18:0];
			a3x3_s3 <= a3x3_w;
			a2_s3   <= a2_w[19:0];
			a1_s3   <= a1_w[16:0];
			p1_s3   <= p1;
			f_s3    <= f_s2;
		end
		if (adv.ld_s4) begin
			m1_s4  <= 36'(a3_s3) * 36'(fx_s3);
			md1_s4 <= 38'(a3x3_s3) * 38'(fx_s3);
			a2_s4  <= a2_s3;
			a1_s4  <= a1_s3;
			p1_s4  <= p1_s3;
			f_s4   <= f_s3;
		end
		if (adv.ld_s5) begin
			u_s5  <= 37'(m1_s4) + (37'(a2_s4) <<< 16);
			v_s5  <= 39'(md1_s4) + (39'(a2_s4) <<< 17);
			a1_s5 <= a1_s4;
			p1_s5 <= p1_s4;
			f_s5  <= f_s4;
		end
		if (adv.ld_s6) begin
			uf_s6 <= 54'(u_s5) * 54'(fx_s5);
			vf_s6 <= 56'(v_s5) * 56'(fx_s5);
			a1_s6 <= a1_s5;
			p1_s6 <= p1_s5;
			f_s6  <= f_s5;
		end
		if (adv.ld_s7) begin
			h_s7   <= hsum[55:16];
			der_s7 <= crle_pkg::sat20(25'(signed'(gsum[56:33])));
			p1_s7  <= p1_s6;
			f_s7   <= f_s6;
		end
		if (adv.ld_s8) begin
			hf_s8  <= 57'(h_s7) * 57'(fx_s7);
			der_s8 <= der_s7;
			p1_s8  <= p1_s7;
		end
		if (adv.ld_s9) begin
			pos <= crle_pkg::sat20(pos_full);
			der <= der_s8;
		end
	end

endmodule
`default_nettype wire

// ===== design/catmull_rom_loop_evaluator.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// catmull_rom_loop_evaluator
// closed-loop uniform catmull-rom position and derivative evaluator
// ----------------------------------------------------------------------------
// Words enter on s_tvalid/s_tready. s_tuser[0] is the mode: a write word
// stores point_index/coord_x/y/z in the point table and gives no result;
// an evaluate word carries global_t and gives one result word on
// m_tvalid/m_tready holding saturated position and derivative, Q8.12.
// cfg_valid/cfg_data sets the loop length (clamped to 4..MAX_POINTS);
// cfg_ready is always high.
// Throughput: one word per cycle while m_tready stays high; the pipeline
// s1..s9 has a valid bit per stage, each stage fills while the one below
// moves, so bubbles are closed.
// The point table is four copies of a small ram (one per neighbor tap),
// written together, each read once per word at the s1 to s2 step.
// When m_tready is low the last stage holds its word and stages above keep
// filling until full; then s_tready drops. Nothing is lost or repeated.
// Reset clears the valid bits and sets the loop length to 5; the table is
// not cleared and must be written before it is evaluated.
// ----------------------------------------------------------------------------
module catmull_rom_loop_evaluator #(
	parameter int MAX_POINTS = 8
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// point_index, coord_x, coord_y, coord_z, global_t, zero pad
	input  wire logic [71:0]  s_tdata,
	// mode
	input  wire logic [0:0]   s_tuser,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// pos_x, pos_y, pos_z, der_x, der_y, der_z
	output logic      [119:0] m_tdata,
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic [3:0]   cfg_data
);

	localparam int AW = $clog2(MAX_POINTS);

	logic [2:0]  in_index;
	logic [15:0] in_x, in_y, in_z, in_t;
	logic        in_acc;
	logic        tbl_we;
	logic [47:0] tbl_wdata;

	logic [3:0]  loop_len_q;
	logic [3:0]  n_d;

	logic        valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic        valid_s6, valid_s7, valid_s8, valid_s9;
	logic        rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5;
	logic        rdy_s6, rdy_s7, rdy_s8, rdy_s9;

	logic [19:0] scaled_s1;
	logic [3:0]  n_s1;
	logic [3:0]  seg, idx0, idx1, idx2, idx3;
	logic [15:0] f_s2;

	logic [47:0] pt0, pt1, pt2, pt3;
	crle_pkg::crle_adv_t adv;
	logic signed [19:0] pos_x, pos_y, pos_z, der_x, der_y, der_z;

	assign in_index = s_tdata[2:0];
	assign in_x     = s_tdata[18:3];
	assign in_y     = s_tdata[34:19];
	assign in_z     = s_tdata[50:35];
	assign in_t     = s_tdata[66:51];

	assign in_acc    = s_tvalid && s_tready;
	assign tbl_we    = in_acc && (s_tuser[0] == crle_pkg::MODE_WRITE) &&
	                   (32'(in_index) < MAX_POINTS);
	assign tbl_wdata = {in_z, in_y, in_x};

	// configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			loop_len_q <= crle_pkg::RESET_POINTS;
		else if (cfg_valid && cfg_ready)
			loop_len_q <= cfg_data;
	end

	always_comb begin
		if (loop_len_q < crle_pkg::MIN_POINTS)
			n_d = crle_pkg::MIN_POINTS;
		else if (32'(loop_len_q) > MAX_POINTS)
			n_d = 4'(MAX_POINTS);
		else
			n_d = loop_len_q;
	end

	// stage flow control
	assign rdy_s9 = !valid_s9 || m_tready;
	assign rdy_s8 = !valid_s8 || rdy_s9;
	assign rdy_s7 = !valid_s7 || rdy_s8;
	assign rdy_s6 = !valid_s6 || rdy_s7;
	assign rdy_s5 = !valid_s5 || rdy_s6;
	assign rdy_s4 = !valid_s4 || rdy_s5;
	assign rdy_s3 = !valid_s3 || rdy_s4;
	assign rdy_s2 = !valid_s2 || rdy_s3;
	assign rdy_s1 = !valid_s1 || rdy_s2;
	assign s_tready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
			valid_s8 <= 1'b0;
			valid_s9 <= 1'b0;
		end else begin
			if (rdy_s1)
				valid_s1 <= s_tvalid && (s_tuser[0] == crle_pkg::MODE_EVAL);
			if (rdy_s2)
				valid_s2 <= valid_s1;
			if (rdy_s3)
				valid_s3 <= valid_s2;
			if (rdy_s4)
				valid_s4 <= valid_s3;
			if (rdy_s5)
				valid_s5 <= valid_s4;
			if (rdy_s6)
				valid_s6 <= valid_s5;
			if (rdy_s7)
				valid_s7 <= valid_s6;
			if (rdy_s8)
				valid_s8 <= valid_s7;
			if (rdy_s9)
				valid_s9 <= valid_s8;
		end
	end

	// s1: scale the loop parameter by the point count
	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			scaled_s1 <= 20'(in_t) * 20'(n_d);
			n_s1      <= n_d;
		end
		if (rdy_s2)
			f_s2 <= scaled_s1[15:0];
	end

	// neighbor indices with wrap-around
	assign seg  = scaled_s1[19:16];
	assign idx1 = seg;
	assign idx0 = (seg == 4'd0) ? n_s1 - 4'd1 : seg - 4'd1;
	assign idx2 = (seg + 4'd1 == n_s1) ? 4'd0 : seg + 4'd1;
	assign idx3 = (idx2 + 4'd1 == n_s1) ? 4'd0 : idx2 + 4'd1;

	crle_ram #(.WIDTH(crle_pkg::POINT_W), .DEPTH(MAX_POINTS)) u_tbl0 (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (AW'(in_index)),
		.wdata (tbl_wdata),
		.re    (rdy_s2),
		.raddr (AW'(idx0)),
		.rdata (pt0)
	);

	crle_ram #(.WIDTH(crle_pkg::POINT_W), .DEPTH(MAX_POINTS)) u_tbl1 (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (AW'(in_index)),
		.wdata (tbl_wdata),
		.re    (rdy_s2),
		.raddr (AW'(idx1)),
		.rdata (pt1)
	);

	crle_ram #(.WIDTH(crle_pkg::POINT_W), .DEPTH(MAX_POINTS)) u_tbl2 (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (AW'(in_index)),
		.wdata (tbl_wdata),
		.re    (rdy_s2),
		.raddr (AW'(idx2)),
		.rdata (pt2)
	);

	crle_ram #(.WIDTH(crle_pkg::POINT_W), .DEPTH(MAX_POINTS)) u_tbl3 (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (AW'(in_index)),
		.wdata (tbl_wdata),
		.re    (rdy_s2),
		.raddr (AW'(idx3)),
		.rdata (pt3)
	);

	assign adv.ld_s3 = rdy_s3;
	assign adv.ld_s4 = rdy_s4;
	assign adv.ld_s5 = rdy_s5;
	assign adv.ld_s6 = rdy_s6;
	assign adv.ld_s7 = rdy_s7;
	assign adv.ld_s8 = rdy_s8;
	assign adv.ld_s9 = rdy_s9;

	crle_lane u_lane_x (
		.clk  (clk),
		.adv  (adv),
		.f_s2 (f_s2),
		.p0   (pt0[15:0]),
		.p1   (pt1[15:0]),
		.p2   (pt2[15:0]),
		.p3   (pt3[15:0]),
		.pos  (pos_x),
		.der  (der_x)
	);

	crle_lane u_lane_y (
		.clk  (clk),
		.adv  (adv),
		.f_s2 (f_s2),
		.p0   (pt0[31:16]),
		.p1   (pt1[31:16]),
		.p2   (pt2[31:16]),
		.p3   (pt3[31:16]),
		.pos  (pos_y),
		.der  (der_y)
	);

	crle_lane u_lane_z (
		.clk  (clk),
		.adv  (adv),
		.f_s2 (f_s2),
		.p0   (pt0[47:32]),
		.p1   (pt1[47:32]),
		.p2   (pt2[47:32]),
		.p3   (pt3[47:32]),
		.pos  (pos_z),
		.der  (der_z)
	);

	assign m_tvalid = valid_s9;
	assign m_tdata  = {der_z, der_y, der_x, pos_z, pos_y, pos_x};

`ifndef ASSERT_OFF
	// an accepted evaluate word lands in s1
	a_eval_enters: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser[0] == crle_pkg::MODE_EVAL) |=> valid_s1)
		else $error("evaluate word not captured in s1");

	// a write word never becomes a result
	a_write_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser[0] == crle_pkg::MODE_WRITE) |=> !valid_s1)
		else $error("write word entered the evaluation pipe");

	// the four taps stay inside the loop and the middle tap differs from its two neighbors
	a_taps_in_loop: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (idx0 < n_s1) && (idx1 < n_s1) && (idx2 < n_s1) &&
		(idx3 < n_s1) && (idx1 != idx2) && (idx0 != idx1))
		else $error("neighbor index outside the loop");

	// clamped count is always usable
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (n_s1 >= crle_pkg::MIN_POINTS) && (32'(n_s1) <= MAX_POINTS))
		else $error("point count out of range");

	// a stalled last stage keeps its word and stage 8 cannot push into it
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s9 && !m_tready |-> !rdy_s8 || !valid_s8)
		else $error("stage 8 advanced into a stalled output");
`endif

endmodule
`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Testbench for catmull_rom_loop_evaluator. It fills the point table, then
// sends point writes and curve evaluations through the stream input. Each
// evaluation is predicted from a local copy of the point table and the point
// count, and each result word is compared field by field with the oldest
// prediction. The count register is changed between phases once the block
// has drained. Sender gaps and receiver stalls vary from phase to phase, and
// one long receiver hold-off fills the pipeline.
// ----------------------------------------------------------------------------
module tb;

	localparam int TABLE_SIZE = 8;
	localparam int TIMEOUT = 400000;
	localparam int SETTLE = 16;
	localparam int FIELD_W = crle_pkg::RES_W;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [71:0] s_tdata = '0;
	logic [0:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [119:0] m_tdata;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [3:0] cfg_data = '0;

	// local copy of the block state
	logic signed [crle_pkg::COORD_W-1:0] pt_table [TABLE_SIZE][3];
	logic [crle_pkg::COUNT_W-1:0] loop_count = crle_pkg::RESET_POINTS;
	logic [119:0] pending_curves [$];

	int errors = 0;
	int cycle_count = 0;
	int src_idle = 0;
	int sink_stall = 0;
	logic sink_hold = 1'b0;
	string field_name [6] = '{"pos_x", "pos_y", "pos_z", "der_x", "der_y", "der_z"};

	catmull_rom_loop_evaluator #(
		.MAX_POINTS(TABLE_SIZE)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	function automatic longint round_shift(input longint x, input int s);
		return (x + (longint'(1) << (s - 1))) >>> s;
	endfunction

	function automatic logic [FIELD_W-1:0] clamp_q812(input longint v);
		if (v > 524287)
			return 20'h7FFFF;
		else if (v < -524288)
			return 20'h80000;
		else
			return v[FIELD_W-1:0];
	endfunction

	// position and derivative word for one global parameter
	function automatic logic [119:0] eval_curve(input logic [crle_pkg::PARAM_W-1:0] gt);
		int unsigned n, seg, i0, i1, i2, i3;
		longint scaled, f, p0, p1, p2, p3, a3, a2, a1, h, pos, g;
		logic [119:0] word;
		word = '0;
		n = 32'(loop_count);
		if (n < crle_pkg::MIN_POINTS)
			n = crle_pkg::MIN_POINTS;
		if (n > TABLE_SIZE)
			n = TABLE_SIZE;
		scaled = longint'(gt) * n;
		seg = 32'(scaled >> 16);
		f = scaled & 64'hFFFF;
		i0 = (seg + n - 1) % n;
		i1 = (i0 + 1) % n;
		i2 = (i1 + 1) % n;
		i3 = (i2 + 1) % n;
		for (int k = 0; k < 3; k++) begin
			p0 = pt_table[i0][k];
			p1 = pt_table[i1][k];
			p2 = pt_table[i2][k];
			p3 = pt_table[i3][k];
			a3 = -p0 + 3 * p1 - 3 * p2 + p3;
			a2 = 2 * p0 - 5 * p1 + 4 * p2 - p3;
			a1 = p2 - p0;
			h = round_shift((a3 * f + a2 * 65536) * f + a1 * (longint'(1) << 32), 16);
			pos = p1 + round_shift(h * f, 33);
			g = (3 * a3 * f + 2 * a2 * 65536) * f + a1 * (longint'(1) << 32);
			word[k * FIELD_W +: FIELD_W] = clamp_q812(pos);
			word[(k + 3) * FIELD_W +: FIELD_W] = clamp_q812(round_shift(g, 33));
		end
		return word;
	endfunction

	function automatic logic [crle_pkg::COORD_W-1:0] rand_coord();
		case ($urandom_range(7))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return 16'h0000;
			default: return 16'($urandom);
		endcase
	endfunction

	// results are checked first: they belong to words taken on earlier edges
	always @(posedge clk) begin
		logic [119:0] want;
		logic [2:0] slot;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (pending_curves.size() == 0) begin
					$display("%0t: result word with nothing expected: %h", $time, m_tdata);
					errors++;
				end else begin
					want = pending_curves.pop_front();
					for (int k = 0; k < 6; k++) begin
						if (want[k * FIELD_W +: FIELD_W] !== m_tdata[k * FIELD_W +: FIELD_W]) begin
							$display("%0t: %s expected %h got %h", $time, field_name[k],
								want[k * FIELD_W +: FIELD_W], m_tdata[k * FIELD_W +: FIELD_W]);
							errors++;
						end
					end
				end
			end
			if (s_tvalid && s_tready) begin
				if (s_tuser[0] == crle_pkg::MODE_EVAL) begin
					pending_curves.push_back(eval_curve(s_tdata[66:51]));
				end else begin
					slot = s_tdata[2:0];
					pt_table[slot][0] = s_tdata[18:3];
					pt_table[slot][1] = s_tdata[34:19];
					pt_table[slot][2] = s_tdata[50:35];
				end
			end
			if (cfg_valid && cfg_ready)
				loop_count = cfg_data;
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == TIMEOUT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	always @(negedge clk) begin
		m_tready <= !sink_hold && ($urandom_range(99) >= sink_stall);
	end

	// returns at a falling edge with s_tvalid still high
	task automatic send_word(input logic mode, input logic [2:0] idx,
		input logic [15:0] cx, input logic [15:0] cy, input logic [15:0] cz,
		input logic [15:0] gt);
		while ($urandom_range(99) < src_idle) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= mode;
		s_tdata <= {5'b0, gt, cz, cy, cx, idx};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_point(input logic [2:0] idx, input logic [15:0] cx,
		input logic [15:0] cy, input logic [15:0] cz);
		send_word(crle_pkg::MODE_WRITE, idx, cx, cy, cz, 16'($urandom));
	endtask

	task automatic eval_at(input logic [15:0] gt);
		send_word(crle_pkg::MODE_EVAL, 3'($urandom), 16'($urandom), 16'($urandom),
			16'($urandom), gt);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending_curves.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic set_count(input logic [3:0] value);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic hold_sink(input int cycles);
		sink_hold <= 1'b1;
		repeat (cycles) @(negedge clk);
		sink_hold <= 1'b0;
	endtask

	// every slot is written before anything is evaluated
	task automatic test_table_fill();
		write_point(3'd0, 16'h7FFF, 16'h8000, 16'h0000);
		write_point(3'd1, 16'h8000, 16'h7FFF, 16'h0001);
		write_point(3'd2, 16'h7FFF, 16'h8000, 16'hFFFF);
		write_point(3'd3, 16'h8000, 16'h7FFF, 16'h1000);
		for (int i = 4; i < TABLE_SIZE; i++)
			write_point(3'(i), rand_coord(), rand_coord(), rand_coord());
	endtask

	task automatic test_param_edges();
		logic [15:0] edge_param [10] = '{16'h0000, 16'h0001, 16'h7FFF, 16'h8000, 16'hFFFE,
			16'hFFFF, 16'h3333, 16'h3334, 16'hCCCC, 16'h5555};
		foreach (edge_param[i])
			eval_at(edge_param[i]);
	endtask

	// counts below the minimum and above the table size are clamped
	task automatic test_count_extremes();
		logic [3:0] counts [4] = '{4'd15, 4'd0, 4'd8, 4'd4};
		foreach (counts[i]) begin
			set_count(counts[i]);
			eval_at(16'hFFFF);
			eval_at(16'($urandom));
		end
	endtask

	task automatic test_random_traffic();
		int idle_src [4] = '{0, 86, 0, 10};
		int idle_sink [4] = '{0, 0, 86, 10};
		for (int ph = 0; ph < 4; ph++) begin
			src_idle = idle_src[ph];
			sink_stall = idle_sink[ph];
			for (int half = 0; half < 2; half++) begin
				set_count(4'($urandom_range(15)));
				repeat (175) begin
					if ($urandom_range(99) < 30)
						write_point(3'($urandom), rand_coord(), rand_coord(), rand_coord());
					else
						eval_at(16'($urandom));
				end
			end
		end
	endtask

	// receiver holds off long enough for the input to stall
	task automatic test_backpressure();
		src_idle = 0;
		sink_stall = 0;
		set_count(4'd7);
		fork
			hold_sink(300);
			repeat (50)
				eval_at(16'($urandom));
		join
		drain();
		src_idle = 20;
		sink_stall = 20;
		repeat (20)
			eval_at(16'($urandom));
	endtask

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_table_fill();
		test_param_edges();
		test_count_extremes();
		test_random_traffic();
		test_backpressure();
		drain();
		repeat (SETTLE) @(posedge clk);
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
